### rtl/core/gttpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gttpr_pkg: shared types, constants and font ROM
// Holds the 5x7 glyph table, the pitch constants and the word passed from the
// glyph scanner to the rectangle emitter.
// ----------------------------------------------------------------------------
package gttpr_pkg;

  localparam int GLYPH_BITS = 35;
  localparam int GLYPH_COLS = 5;

  localparam logic [9:0] ORIGIN_X   = 10'd24;
  localparam logic [5:0] ORIGIN_Y   = 6'd24;
  localparam logic [5:0] LINE_PITCH = 6'd20;

  // Register indexes, taken from paddr[2]
  localparam logic REG_SURFACE_WIDTH  = 1'b0;
  localparam logic REG_SURFACE_HEIGHT = 1'b1;

  localparam logic [13:0] SURFACE_WIDTH_RST  = 14'd1024;
  localparam logic [13:0] SURFACE_HEIGHT_RST = 14'd768;

  typedef struct packed {
    logic       cand;    // visible lit bit found on this step
    logic       flush;   // final step of the glyph scan
    logic [9:0] left;
    logic [5:0] top;
    logic [9:0] right;
    logic [5:0] bottom;
  } scan_word_t;

  function automatic logic [4:0] r(input int v);
    r = v[4:0];
  endfunction

  // Row 0 lands in the top five bits; bit 4 of each row is the leftmost pixel
  function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [7:0] code);
    logic [GLYPH_BITS-1:0] g;
    g = '0;
    case (code)
      8'h41: g = {r(14), r(17), r(17), r(31), r(17), r(17), r(17)};
      8'h42: g = {r(30), r(17), r(17), r(30), r(17), r(17), r(30)};
      8'h43: g = {r(14), r(17), r(16), r(16), r(16), r(17), r(14)};
      8'h44: g = {r(30), r(17), r(17), r(17), r(17), r(17), r(30)};
      8'h45: g = {r(31), r(16), r(16), r(30), r(16), r(16), r(31)};
      8'h46: g = {r(31), r(16), r(16), r(30), r(16), r(16), r(16)};
      8'h47: g = {r(14), r(17), r(16), r(23), r(17), r(17), r(15)};
      8'h48: g = {r(17), r(17), r(17), r(31), r(17), r(17), r(17)};
      8'h49: g = {r(14), r(4),  r(4),  r(4),  r(4),  r(4),  r(14)};
      8'h4A: g = {r(7),  r(2),  r(2),  r(2),  r(18), r(18), r(12)};
      8'h4B: g = {r(17), r(18), r(20), r(24), r(20), r(18), r(17)};
      8'h4C: g = {r(16), r(16), r(16), r(16), r(16), r(16), r(31)};
      8'h4D: g = {r(17), r(27), r(21), r(21), r(17), r(17), r(17)};
      8'h4E: g = {r(17), r(25), r(21), r(19), r(17), r(17), r(17)};
      8'h4F: g = {r(14), r(17), r(17), r(17), r(17), r(17), r(14)};
      8'h50: g = {r(30), r(17), r(17), r(30), r(16), r(16), r(16)};
      8'h51: g = {r(14), r(17), r(17), r(17), r(21), r(18), r(13)};
      8'h52: g = {r(30), r(17), r(17), r(30), r(20), r(18), r(17)};
      8'h53: g = {r(15), r(16), r(16), r(14), r(1),  r(1),  r(30)};
      8'h54: g = {r(31), r(4),  r(4),  r(4),  r(4),  r(4),  r(4)};
      8'h55: g = {r(17), r(17), r(17), r(17), r(17), r(17), r(14)};
      8'h56: g = {r(17), r(17), r(17), r(17), r(17), r(10), r(4)};
      8'h57: g = {r(17), r(17), r(17), r(21), r(21), r(21), r(10)};
      8'h58: g = {r(17), r(17), r(10), r(4),  r(10), r(17), r(17)};
      8'h59: g = {r(17), r(17), r(10), r(4),  r(4),  r(4),  r(4)};
      8'h5A: g = {r(31), r(1),  r(2),  r(4),  r(8),  r(16), r(31)};
      8'h30: g = {r(14), r(17), r(19), r(21), r(25), r(17), r(14)};
      8'h31: g = {r(4),  r(12), r(4),  r(4),  r(4),  r(4),  r(14)};
      8'h32: g = {r(14), r(17), r(1),  r(2),  r(4),  r(8),  r(31)};
      8'h33: g = {r(30), r(1),  r(1),  r(14), r(1),  r(1),  r(30)};
      8'h34: g = {r(2),  r(6),  r(10), r(18), r(31), r(2),  r(2)};
      8'h35: g = {r(31), r(16), r(16), r(30), r(1),  r(1),  r(30)};
      8'h36: g = {r(14), r(16), r(16), r(30), r(17), r(17), r(14)};
      8'h37: g = {r(31), r(1),  r(2),  r(4),  r(8),  r(8),  r(8)};
      8'h38: g = {r(14), r(17), r(17), r(14), r(17), r(17), r(14)};
      8'h39: g = {r(14), r(17), r(17), r(15), r(1),  r(1),  r(14)};
      8'h2E: g = {r(0),  r(0),  r(0),  r(0),  r(0),  r(12), r(12)};
      8'h2B: g = {r(0),  r(4),  r(4),  r(31), r(4),  r(4),  r(0)};
      8'h2D: g = {r(0),  r(0),  r(0),  r(31), r(0),  r(0),  r(0)};
      8'h2F: g = {r(1),  r(2),  r(2),  r(4),  r(8),  r(8),  r(16)};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

### rtl/core/gttpr_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gttpr_scan: glyph bit scanner
// Shifts the 35 glyph bits out one per step, tracks the pixel position and
// clips it against the surface, then flags the end of the cell.
// ----------------------------------------------------------------------------
module gttpr_scan
  import gttpr_pkg::*;
#(
  parameter int MAX_COLUMNS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       char_code,
  input  logic             line_index,
  input  logic [5:0]       column_index,
  input  logic [13:0]      surface_width,
  input  logic [13:0]      surface_height,
  input  logic             go,
  output logic             busy,
  output scan_word_t       word
);

  logic [GLYPH_BITS-1:0] bits;
  logic [5:0]            cnt;
  logic [2:0]            xpos;
  logic [9:0]            left;
  logic [9:0]            base;
  logic [5:0]            top;

  logic                  accept;
  logic                  col_ok;
  logic [9:0]            base_next;
  logic                  step;
  logic                  last_step;
  logic [13:0]           right_sum;
  logic [13:0]           bottom_sum;
  logic                  visible;

  assign accept    = in_valid && !busy;
  assign col_ok    = {1'b0, column_index} < 7'(MAX_COLUMNS);
  // col * 12 as (col << 3) + (col << 2)
  assign base_next = ORIGIN_X + {1'b0, column_index, 3'b000} + {2'b00, column_index, 2'b00};
  assign step      = busy && go;
  assign last_step = cnt == 6'(GLYPH_BITS);

  assign right_sum  = {4'b0000, left} + 14'd2;
  assign bottom_sum = {8'h00, top} + 14'd2;
  assign visible    = ({4'b0000, left} < surface_width) && ({8'h00, top} < surface_height);

  always_comb begin
    word.cand   = step && !last_step && bits[GLYPH_BITS-1] && visible;
    word.flush  = step && last_step;
    word.left   = left;
    word.top    = top;
    word.right  = (right_sum > surface_width) ? surface_width[9:0] : right_sum[9:0];
    word.bottom = (bottom_sum > surface_height) ? surface_height[5:0] : bottom_sum[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
      bits <= col_ok ? font_glyph(char_code) : '0;
      xpos <= '0;
      base <= base_next;
      left <= base_next;
      top  <= line_index ? (ORIGIN_Y + LINE_PITCH) : ORIGIN_Y;
    end else if (step) begin
      if (last_step) begin
        busy <= 1'b0;
      end else begin
        cnt  <= cnt + 6'd1;
        bits <= {bits[GLYPH_BITS-2:0], 1'b0};
        // advance to next pixel, wrap to next row after the fifth column
        if (xpos == 3'(GLYPH_COLS - 1)) begin
          xpos <= '0;
          left <= base;
          top  <= top + 6'd2;
        end else begin
          xpos <= xpos + 3'd1;
          left <= left + 10'd2;
        end
      end
    end
  end

endmodule

### rtl/core/gttpr_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gttpr_emit: rectangle emitter
// Holds one rectangle back until the next one or the end of the cell shows
// whether it is the last, then loads it into the output register.
// ----------------------------------------------------------------------------
module gttpr_emit
  import gttpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scan_word_t word,
  input  logic       out_stall,
  output logic       go,
  output logic       pending,
  output logic       out_valid,
  output logic [9:0] rect_left,
  output logic [5:0] rect_top,
  output logic [9:0] rect_right,
  output logic [5:0] rect_bottom,
  output logic       last_rect
);

  logic [9:0] pend_left;
  logic [5:0] pend_top;
  logic [9:0] pend_right;
  logic [5:0] pend_bottom;
  logic       load;

  assign go   = !out_valid || !out_stall;
  assign load = (word.cand || word.flush) && pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
      if (word.cand) begin
        pending <= 1'b1;
      end else if (word.flush) begin
        pending <= 1'b0;
      end
    end
    if (word.cand) begin
      pend_left   <= word.left;
      pend_top    <= word.top;
      pend_right  <= word.right;
      pend_bottom <= word.bottom;
    end
    if (load) begin
      rect_left   <= pend_left;
      rect_top    <= pend_top;
      rect_right  <= pend_right;
      rect_bottom <= pend_bottom;
      last_rect   <= word.flush;
    end
  end

endmodule

### rtl/core/glyph_text_to_pixel_rects.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_to_pixel_rects: 5x7 character generator for a text overlay
// Turns one character word into the 2x2 pixel rectangles of its glyph.
// ----------------------------------------------------------------------------
// Input words (char_code, line_index, column_index) arrive on in_valid /
// in_stall; rectangle words leave on out_valid / out_stall, one per lit and
// visible glyph pixel, scanned row by row from the left. last_rect marks the
// final rectangle of a character; blank codes, columns beyond MAX_COLUMNS and
// fully clipped glyphs give no words at all.
// A character passes through an accept, 35 scan steps (one glyph bit each)
// and a flush step that releases the held-back last rectangle; in_stall
// stays high for the whole scan. Each rectangle waits in a one-word hold
// stage and is loaded into the output register at the step that scans the
// next lit and visible pixel or at the flush step. When the receiver stalls,
// the scan pauses on that step and the output word holds. surface_width and
// surface_height are written over the APB port at byte addresses 0 and 4;
// the user is to write them only while idle, which the block does not enforce.
// Reset sets them to 1024 and 768 and clears all handshake state.
// ----------------------------------------------------------------------------
module glyph_text_to_pixel_rects
  import gttpr_pkg::*;
#(
  parameter int MAX_COLUMNS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        line_index,
  input  logic [5:0]  column_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  rect_left,
  output logic [5:0]  rect_top,
  output logic [9:0]  rect_right,
  output logic [5:0]  rect_bottom,
  output logic        last_rect
);

  logic [13:0] surface_width;
  logic [13:0] surface_height;
  logic        busy;
  logic        go;
  logic        pending;
  scan_word_t  word;

  assign pready   = 1'b1;
  assign in_stall = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= SURFACE_WIDTH_RST;
      surface_height <= SURFACE_HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SURFACE_WIDTH:  surface_width  <= pwdata[13:0];
        REG_SURFACE_HEIGHT: surface_height <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SURFACE_WIDTH:  prdata = {18'h00000, surface_width};
      REG_SURFACE_HEIGHT: prdata = {18'h00000, surface_height};
      default:            prdata = '0;
    endcase
  end

  gttpr_scan #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .char_code     (char_code),
    .line_index    (line_index),
    .column_index  (column_index),
    .surface_width (surface_width),
    .surface_height(surface_height),
    .go            (go),
    .busy          (busy),
    .word          (word)
  );

  gttpr_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .word       (word),
    .out_stall  (out_stall),
    .go         (go),
    .pending    (pending),
    .out_valid  (out_valid),
    .rect_left  (rect_left),
    .rect_top   (rect_top),
    .rect_right (rect_right),
    .rect_bottom(rect_bottom),
    .last_rect  (last_rect)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("scanner not busy after accepting a word");

  a_rect_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rect_left < rect_right) && (rect_top < rect_bottom))
    else $error("empty rectangle emitted");

  a_no_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !pending)
    else $error("rectangle still held back after the scan ended");

endmodule

### tb/sv/tb_glyph_text_to_pixel_rects.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_text_to_pixel_rects: self-checking bench for the text overlay
// character generator
// Feeds character words through a queue-driven driver, predicts the clipped
// 2x2 rectangles of every glyph from its own font table and checks each
// rectangle word in order. The run walks through several surface sizes,
// from zero and one pixel to the register maximum, and applies random idling
// on both sides plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_glyph_text_to_pixel_rects
  import gttpr_pkg::*;
();

  localparam int TEXT_ORIGIN = 24;
  localparam int CHAR_PITCH  = 12;
  localparam int ROW_PITCH   = 20;
  localparam int DOT_SIZE    = 2;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [7:0] code;
    logic       line_no;
    logic [5:0] col;
  } char_word_t;

  typedef struct packed {
    logic [9:0] left;
    logic [5:0] top;
    logic [9:0] right;
    logic [5:0] bottom;
    logic       last;
  } rect_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = '0;
  logic        line_index = 1'b0;
  logic [5:0]  column_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  rect_left;
  logic [5:0]  rect_top;
  logic [9:0]  rect_right;
  logic [5:0]  rect_bottom;
  logic        last_rect;

  glyph_text_to_pixel_rects u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .line_index   (line_index),
    .column_index (column_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rect_left    (rect_left),
    .rect_top     (rect_top),
    .rect_right   (rect_right),
    .rect_bottom  (rect_bottom),
    .last_rect    (last_rect)
  );

  always #2 clk = ~clk;

  char_word_t text_q[$];
  rect_word_t rect_q[$];

  int  surf_w = 1024;
  int  surf_h = 768;
  int  errors = 0;
  int  chars_taken = 0;
  int  blank_chars = 0;
  int  rects_checked = 0;
  int  settings_done = 0;
  bit  calm = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  gap_cnt = 0;
  int  stall_cnt = 0;
  logic in_fire = 1'b0;
  char_word_t next_char;

  // 5x7 font, row 0 in the top bits, leftmost pixel first in each row
  function automatic logic [34:0] font_bitmap(input logic [7:0] code);
    logic [34:0] rows;
    case (code)
      "A": rows = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "B": rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      "C": rows = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      "D": rows = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      "E": rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      "F": rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      "G": rows = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      "H": rows = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "I": rows = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      "J": rows = {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
      "K": rows = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      "L": rows = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      "M": rows = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      "N": rows = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      "O": rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "P": rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      "Q": rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      "R": rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      "S": rows = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      "T": rows = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      "U": rows = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "V": rows = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      "W": rows = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      "X": rows = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      "Y": rows = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      "Z": rows = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      "0": rows = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      "1": rows = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      "2": rows = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      "3": rows = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      "4": rows = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      "5": rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      "6": rows = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      "7": rows = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      "8": rows = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      "9": rows = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      ".": rows = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
      "+": rows = {5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0};
      "-": rows = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      "/": rows = {5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16};
      default: rows = '0;
    endcase
    return rows;
  endfunction

  // Queue the clipped rectangles of one character; hold each one back until
  // the next is known so the final one can carry the last mark
  task automatic render_glyph(input logic [7:0] code, input logic line_no,
                              input logic [5:0] col);
    logic [34:0] rows;
    rect_word_t  held;
    rect_word_t  cur;
    bit          have;
    int          left, top, right, bottom;
    rows = font_bitmap(code);
    have = 1'b0;
    held = '0;
    for (int y = 0; y < 7; y++) begin
      for (int x = 0; x < 5; x++) begin
        if (rows[34 - 5 * y - x]) begin
          left   = TEXT_ORIGIN + int'(col) * CHAR_PITCH + x * DOT_SIZE;
          top    = TEXT_ORIGIN + int'(line_no) * ROW_PITCH + y * DOT_SIZE;
          right  = left + DOT_SIZE;
          bottom = top + DOT_SIZE;
          if (right > surf_w) right = surf_w;
          if (bottom > surf_h) bottom = surf_h;
          if (left < right && top < bottom) begin
            cur.left   = left[9:0];
            cur.top    = top[5:0];
            cur.right  = right[9:0];
            cur.bottom = bottom[5:0];
            cur.last   = 1'b0;
            if (have) rect_q.push_back(held);
            held = cur;
            have = 1'b1;
          end
        end
      end
    end
    if (have) begin
      held.last = 1'b1;
      rect_q.push_back(held);
    end else begin
      blank_chars++;
    end
  endtask

  task automatic report_mismatch(input string what, input rect_word_t want,
                                 input rect_word_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected l=%0d t=%0d r=%0d b=%0d last=%0b,%s",
               $time, what, want.left, want.top, want.right, want.bottom, want.last,
               $sformatf(" got l=%0d t=%0d r=%0d b=%0d last=%0b",
                         got.left, got.top, got.right, got.bottom, got.last));
  endtask

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    rect_word_t got;
    rect_word_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got.left   = rect_left;
        got.top    = rect_top;
        got.right  = rect_right;
        got.bottom = rect_bottom;
        got.last   = last_rect;
        rects_checked++;
        if (rect_q.size() == 0) begin
          report_mismatch("unexpected rectangle", '0, got);
        end else begin
          want = rect_q.pop_front();
          if (got.left !== want.left || got.top !== want.top ||
              got.right !== want.right || got.bottom !== want.bottom ||
              got.last !== want.last)
            report_mismatch("rectangle mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        render_glyph(char_code, line_index, column_index);
        chars_taken++;
      end
    end
  end

  // Character driver: present the next word once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (!calm && gap_cnt > 0) begin
        in_valid <= 1'b0;
        gap_cnt--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_cnt = $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        next_char = text_q.pop_front();
        in_valid     <= 1'b1;
        char_code    <= next_char.code;
        line_index   <= next_char.line_no;
        column_index <= next_char.col;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Rectangle receiver: random stall bursts plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else if (hold_go && !hold_done) begin
      hold_cnt  = 300;
      hold_done = 1'b1;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_cnt > 0) begin
      out_stall <= 1'b1;
      stall_cnt--;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_cnt = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] pick_char();
    int k;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    k = $urandom_range(0, 39);
    if (k < 26) return 8'("A" + k);
    if (k < 36) return 8'("0" + k - 26);
    case (k)
      36: return ".";
      37: return "+";
      38: return "-";
      default: return "/";
    endcase
  endfunction

  task automatic queue_char(input logic [7:0] code, input logic line_no,
                            input logic [5:0] col);
    char_word_t w;
    w.code    = code;
    w.line_no = line_no;
    w.col     = col;
    text_q.push_back(w);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      queue_char(pick_char(), 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
  endtask

  // Drain everything, then allow for a scan that yields no rectangle
  task automatic wait_idle();
    while (text_q.size() != 0 || in_valid || rect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [13:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {18'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SURFACE_WIDTH) surf_w = int'(value);
    else surf_h = int'(value);
  endtask

  task automatic set_surface(input logic [13:0] w, input logic [13:0] h);
    wait_idle();
    reg_write(REG_SURFACE_WIDTH, w);
    reg_write(REG_SURFACE_HEIGHT, h);
    settings_done++;
  endtask

  initial begin
    #2_000_000;
    $display("timeout: %0d expected rectangles outstanding", rect_q.size());
    $display("tb_glyph_text_to_pixel_rects: done, errors");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset surface: every glyph kind, field extremes, blank codes
    queue_char("A", 1'b0, 6'd0);
    queue_char("B", 1'b1, 6'd63);
    queue_char("Z", 1'b0, 6'd1);
    queue_char("0", 1'b1, 6'd2);
    queue_char("9", 1'b0, 6'd62);
    queue_char(".", 1'b1, 6'd10);
    queue_char("+", 1'b0, 6'd20);
    queue_char("-", 1'b1, 6'd30);
    queue_char("/", 1'b0, 6'd40);
    queue_char("M", 1'b1, 6'd5);
    queue_char("8", 1'b1, 6'd0);
    queue_char(8'h00, 1'b0, 6'd0);
    queue_char(8'hFF, 1'b1, 6'd63);
    queue_char(" ", 1'b0, 6'd7);
    queue_char(8'h80, 1'b1, 6'd8);
    queue_char("a", 1'b0, 6'd9);
    queue_char(8'h7F, 1'b1, 6'd42);
    queue_random(22);

    // zero width or height drops everything
    set_surface(14'd0, 14'd16383);
    queue_char("B", 1'b0, 6'd0);
    queue_random(5);
    set_surface(14'd16383, 14'd0);
    queue_char("8", 1'b1, 6'd63);
    queue_random(5);

    // widest surface; the receiver holds off while characters keep coming
    set_surface(14'd16383, 14'd16383);
    queue_random(45);
    hold_go = 1'b1;

    // one-pixel clip at the first cell corner
    set_surface(14'd25, 14'd25);
    queue_char("B", 1'b0, 6'd0);
    queue_char("A", 1'b0, 6'd0);
    queue_char("/", 1'b0, 6'd0);
    queue_char("E", 1'b0, 6'd0);
    queue_random(4);

    // partial clipping somewhere inside the text area
    set_surface(14'($urandom_range(24, 800)), 14'($urandom_range(24, 60)));
    queue_random(20);
    set_surface(14'($urandom_range(24, 800)), 14'($urandom_range(44, 60)));
    queue_random(20);

    set_surface(14'd1, 14'd1);
    queue_random(6);

    // back to reset sizes, no idling on either side
    set_surface(14'd1024, 14'd768);
    calm = 1'b1;
    queue_random(30);

    while (text_q.size() != 0 || in_valid || rect_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    errors += rect_q.size();

    $display("run: %0d characters (%0d without rectangles), %0d rectangles checked",
             chars_taken, blank_chars, rects_checked);
    $display("run: %0d surface settings including zero, one pixel and full range, %0d errors",
             settings_done, errors);
    if (errors == 0) begin
      $display("tb_glyph_text_to_pixel_rects: done, clean");
    end else begin
      $display("tb_glyph_text_to_pixel_rects: done, errors");
    end
    $finish;
  end

endmodule
